[design/assert_macros.svh]
// assertion macros shared by the frame checker rtl
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[design/stxbcc_pkg.sv]
// constants, codes and result type for the stx/etx bcc frame checker
// no dependencies
`default_nettype none

package stxbcc_pkg;

  localparam int HEADER_BYTES_DEF    = 35;
  localparam int MIN_FRAME_BYTES_DEF = 37;

  localparam int JOB_INDEX = 31;
  localparam int LEN_INDEX = 33;

  localparam int POS_W = 17;

  localparam logic [7:0] START_RESET = 8'h02;
  localparam logic [7:0] END_RESET   = 8'h03;

  localparam logic [7:0] CFG_START = 8'd0;
  localparam logic [7:0] CFG_END   = 8'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_END   = 3'd3;
  localparam logic [2:0] ST_BAD_CHECK = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pay;
    logic [2:0]  status;
    logic [7:0]  job;
    logic [15:0] len;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

[design/stx_etx_bcc_frame_checker.sv]
// stx/etx frame checker with xor bcc, one buffer byte per beat
// an accepted byte's result is registered into the output register, or into the skid entry when the output stalls
// throughput: one byte per cycle while the skid entry is empty; output register plus one skid entry
// stall on the input is set only by a full skid entry
// reset: synchronous, clears the frame state and the output and skid valid flags, registers to 2 and 3
`default_nettype none

module stx_etx_bcc_frame_checker import stxbcc_pkg::*; #(
  parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
  parameter int MIN_FRAME_BYTES = MIN_FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             item_kind,
  output logic [7:0]       payload_byte,
  output logic [2:0]       frame_status,
  output logic [7:0]       job_code,
  output logic [15:0]      data_length,
  output logic             last_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

`include "assert_macros.svh"

  localparam int CW = POS_W + 1;
  localparam logic [CW-1:0]    HDR     = CW'(HEADER_BYTES);
  localparam logic [CW-1:0]    MIN_CNT = CW'(MIN_FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_JOB = POS_W'(JOB_INDEX);
  localparam logic [POS_W-1:0] POS_LO  = POS_W'(LEN_INDEX);
  localparam logic [POS_W-1:0] POS_HI  = POS_W'(LEN_INDEX + 1);

  logic [7:0]       start_byte;
  logic [7:0]       end_byte;

  logic [POS_W-1:0] byte_position;
  logic [7:0]       running_check;
  logic [15:0]      length_value;
  logic [7:0]       job_value;
  logic             start_wrong;
  logic             end_wrong;
  logic             status_sent;

  result_t          out_item;
  result_t          skid_item;
  logic             skid_valid;

  logic             accept;
  logic             out_take;

  logic [CW-1:0]    pos_w;
  logic [CW-1:0]    count;
  logic [CW-1:0]    frame_end;
  logic             start_wrong_next;
  logic             end_wrong_next;
  logic [7:0]       job_next;
  logic [15:0]      length_next;
  logic [7:0]       check_next;
  logic             in_frame;
  logic             is_payload;
  logic             done;
  logic             res_valid;
  result_t          res;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
      end_byte   <= END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_START) begin
        start_byte <= cfg_data;
      end else if (cfg_index == CFG_END) begin
        end_byte <= cfg_data;
      end
    end
  end

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // per-byte evaluation
  always_comb begin
    pos_w = CW'(byte_position);
    count = pos_w + CW'(1);

    start_wrong_next = (byte_position == '0) ? (rx_byte != start_byte) : start_wrong;
    job_next         = (byte_position == POS_JOB) ? rx_byte : job_value;
    length_next      = length_value;
    if (byte_position == POS_LO) begin
      length_next = {length_value[15:8], rx_byte};
    end else if (byte_position == POS_HI) begin
      length_next = {rx_byte, length_value[7:0]};
    end

    frame_end      = HDR + CW'(length_next);
    in_frame       = pos_w < (frame_end + CW'(2));
    check_next     = in_frame ? (running_check ^ rx_byte) : running_check;
    is_payload     = (pos_w >= HDR) && (pos_w < frame_end);
    end_wrong_next = (pos_w == frame_end) ? (rx_byte != end_byte) : end_wrong;
    done           = (count >= frame_end + CW'(2)) && (count >= MIN_CNT);

    res        = '0;
    res.job    = job_next;
    res.len    = length_next;
    res_valid  = 1'b0;
    if (!status_sent) begin
      if (done) begin
        res_valid = 1'b1;
        res.kind  = KIND_STATUS;
        res.last  = 1'b1;
        if (start_wrong_next) begin
          res.status = ST_BAD_START;
        end else if (end_wrong_next) begin
          res.status = ST_BAD_END;
        end else if (check_next != 8'd0) begin
          res.status = ST_BAD_CHECK;
        end else begin
          res.status = ST_OK;
        end
      end else if (buffer_end) begin
        res_valid = 1'b1;
        res.kind  = KIND_STATUS;
        res.last  = 1'b1;
        if (count < MIN_CNT) begin
          res.status = ST_SHORT;
        end else if (start_wrong_next) begin
          res.status = ST_BAD_START;
        end else begin
          res.status = ST_SHORT;
        end
      end else if (is_payload) begin
        res_valid = 1'b1;
        res.kind  = KIND_PAYLOAD;
        res.pay   = rx_byte;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_check <= '0;
      length_value  <= '0;
      job_value     <= '0;
      start_wrong   <= 1'b0;
      end_wrong     <= 1'b0;
      status_sent   <= 1'b0;
    end else if (accept) begin
      if (buffer_end) begin
        byte_position <= '0;
        running_check <= '0;
        length_value  <= '0;
        job_value     <= '0;
        start_wrong   <= 1'b0;
        end_wrong     <= 1'b0;
        status_sent   <= 1'b0;
      end else if (!status_sent) begin
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + POS_W'(1);
        end
        running_check <= check_next;
        length_value  <= length_next;
        job_value     <= job_next;
        start_wrong   <= start_wrong_next;
        end_wrong     <= end_wrong_next;
        status_sent   <= done;
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= accept && res_valid;
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_item <= skid_item;
      end
    end else if (!out_valid || out_take) begin
      out_item <= res;
    end else begin
      skid_item <= res;
    end
  end

  assign item_kind    = out_item.kind;
  assign payload_byte = out_item.pay;
  assign frame_status = out_item.status;
  assign job_code     = out_item.job;
  assign data_length  = out_item.len;
  assign last_item    = out_item.last;

  `CHK_NOW(a_skid_behind_out, skid_valid, out_valid)
  `CHK_NEXT(a_clear_on_end, accept && buffer_end, (byte_position == '0) && !status_sent)
  `CHK_NOW(a_sent_after_min, status_sent, CW'(byte_position) >= MIN_CNT)
  `CHK_NOW(a_payload_fields, out_valid && (item_kind == KIND_PAYLOAD), (frame_status == ST_OK) && !last_item)

endmodule

`default_nettype wire
